// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ACT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define ACT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/act_pkg.sv =====
// Shared types, codes and constants of the affine transform core.
`default_nettype none

package act_pkg;

    localparam int COORD_BITS_DEF   = 48;
    localparam int COEF_BITS_DEF    = 20;
    localparam int INVERSE_BITS_DEF = 32;
    localparam int FRAC_BITS        = 16;
    localparam int MUL_DIG          = 25;   // digit width of the shared multiplier
    localparam int ADDR_W           = 6;    // eight 64-bit registers
    localparam int DATA_W           = 64;

    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_REV = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOT_INV = 2'd1;
    localparam logic [1:0] STAT_SAT     = 2'd2;

    localparam logic [2:0] REG_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROW2   = 3'd2;
    localparam logic [2:0] REG_XOFF   = 3'd3;
    localparam logic [2:0] REG_YOFF   = 3'd4;
    localparam logic [2:0] REG_ZOFF   = 3'd5;
    localparam logic [2:0] REG_TOFF   = 3'd6;
    localparam logic [2:0] REG_TSCALE = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ADJ,
        S_ADJ_WAIT,
        S_DET,
        S_DET_WAIT,
        S_CHECK,
        S_DIV,
        S_DIV_WAIT,
        S_TERM,
        S_ROW_WAIT,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic start;
        logic clr;   // clear accumulator before this product
        logic sub;   // subtract product instead of add
    } t_mac_req;

    // Coefficient index pair of one adjugate product: {a, b}, row-major indexes.
    // p = 0 is the added product, p = 1 the subtracted one.
    function automatic logic [7:0] adj_pair(input logic [3:0] k, input logic p);
        logic [15:0] q;
        unique case (k)
            4'd0:    q = {4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    q = {4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    q = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    q = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    q = {4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    q = {4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    q = {4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    q = {4'd1, 4'd6, 4'd0, 4'd7};
            4'd8:    q = {4'd0, 4'd4, 4'd1, 4'd3};
            default: q = '0;
        endcase
        return p ? q[7:0] : q[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== design/act_if.sv =====
// Request and result channel interfaces of the affine transform core.
`default_nettype none

interface act_req_if #(
    parameter int COORD_BITS = act_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
    logic signed [COORD_BITS-1:0] t_in;

    modport source (output valid, command, x_in, y_in, z_in, t_in, input ready);
    modport sink   (input valid, command, x_in, y_in, z_in, t_in, output ready);
endinterface

interface act_rsp_if #(
    parameter int COORD_BITS = act_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic signed [COORD_BITS-1:0] z_out;
    logic signed [COORD_BITS-1:0] t_out;
    logic [1:0]                   status;

    modport source (output valid, x_out, y_out, z_out, t_out, status, input ready);
    modport sink   (input valid, x_out, y_out, z_out, t_out, status, output ready);
endinterface

`default_nettype wire

// ===== design/affine_coordinate_transform_core.sv =====
// Affine 3D-plus-time coordinate transform core, top level.
// Work: one shared multiplier runs every product in NCH digit passes (NCH = 2 at default
//   widths). Forward: 14 products. Reverse with a current inverse: 10 products. Inverse
//   refresh adds 21 products and 10 divides.
// Throughput: one request at a time; the result register frees the input side.
// Reset: synchronous active-low; identity matrix, zero offsets, unit time scale, inverse stale.
`default_nettype none

`include "assert_macros.svh"

module affine_coordinate_transform_core #(
    parameter int COORD_BITS   = act_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS    = act_pkg::COEF_BITS_DEF,
    parameter int INVERSE_BITS = act_pkg::INVERSE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    act_req_if.sink                    i_req,
    act_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [act_pkg::ADDR_W-1:0] paddr,
    input  logic [act_pkg::DATA_W-1:0] pwdata,
    output logic [act_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    localparam int FB    = act_pkg::FRAC_BITS;
    localparam int C     = COEF_BITS;
    localparam int AW    = (C > INVERSE_BITS) ? C : INVERSE_BITS;
    localparam int ADJ_W = 2 * C + 1;
    localparam int BW    = (COORD_BITS + 1 > ADJ_W) ? COORD_BITS + 1 : ADJ_W;
    localparam int ACC_W = AW + BW + 3;
    localparam int DET_W = 3 * C + 1;
    localparam int DEN_W = 3 * C;
    localparam int NUM_W = 2 * C + 2 * FB;
    localparam int RND_W = ACC_W - FB;
    localparam int RW    = 3 * C;
    localparam int DW    = act_pkg::DATA_W;

    localparam logic signed [AW-1:0] ONE_A = {{(AW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [RW-1:0]                r_mrow [3];
    logic signed [COORD_BITS-1:0] r_off  [4];   // x, y, z, t
    logic signed [C-1:0]          r_ts;
    logic signed [C-1:0]          coef   [9];

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[act_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            coef[k] = r_mrow[k / 3][(k % 3) * C +: C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mrow[0] <= RW'(1) << FB;
            r_mrow[1] <= RW'(1) << (C + FB);
            r_mrow[2] <= RW'(1) << (2 * C + FB);
            r_off[0]  <= '0;
            r_off[1]  <= '0;
            r_off[2]  <= '0;
            r_off[3]  <= '0;
            r_ts      <= C'(1) << FB;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                act_pkg::REG_ROW0:   r_mrow[0] <= pwdata[RW-1:0];
                act_pkg::REG_ROW1:   r_mrow[1] <= pwdata[RW-1:0];
                act_pkg::REG_ROW2:   r_mrow[2] <= pwdata[RW-1:0];
                act_pkg::REG_XOFF:   r_off[0]  <= pwdata[COORD_BITS-1:0];
                act_pkg::REG_YOFF:   r_off[1]  <= pwdata[COORD_BITS-1:0];
                act_pkg::REG_ZOFF:   r_off[2]  <= pwdata[COORD_BITS-1:0];
                act_pkg::REG_TOFF:   r_off[3]  <= pwdata[COORD_BITS-1:0];
                act_pkg::REG_TSCALE: r_ts      <= pwdata[C-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            act_pkg::REG_ROW0:   prdata = DW'(r_mrow[0]);
            act_pkg::REG_ROW1:   prdata = DW'(r_mrow[1]);
            act_pkg::REG_ROW2:   prdata = DW'(r_mrow[2]);
            act_pkg::REG_XOFF:   prdata = DW'(r_off[0]);
            act_pkg::REG_YOFF:   prdata = DW'(r_off[1]);
            act_pkg::REG_ZOFF:   prdata = DW'(r_off[2]);
            act_pkg::REG_TOFF:   prdata = DW'(r_off[3]);
            act_pkg::REG_TSCALE: prdata = DW'(r_ts);
            default:             prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    act_pkg::t_state r_state, n_state;
    logic [3:0] r_k, n_k;         // adjugate / divide index
    logic [1:0] r_p, n_p;         // product index within one sum
    logic [1:0] r_row, n_row;     // output row: x, y, z, t
    logic [1:0] r_term, n_term;   // product index within a row
    logic       r_stale, n_stale;
    logic       r_inv_ok, n_inv_ok;
    logic       r_notinv, n_notinv;
    logic       r_sat, n_sat;
    logic       r_ov, n_ov;

    // request, intermediate and result storage
    logic                         r_cmd;
    logic signed [COORD_BITS-1:0] r_in  [4];
    logic signed [ADJ_W-1:0]      r_adj [9];
    logic signed [DET_W-1:0]      r_det;
    logic signed [INVERSE_BITS-1:0] r_inv [10];   // entry 9 is 1/time_scale
    logic signed [COORD_BITS-1:0] r_res [4];
    logic signed [COORD_BITS-1:0] r_ox  [4];
    logic [1:0]                   r_ostat;

    // strobes
    logic in_load, adj_we, det_we, inv_we, res_we, out_load;

    // shared units
    act_pkg::t_mac_req       mac_req;
    logic signed [AW-1:0]    mac_a;
    logic signed [BW-1:0]    mac_b;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] mac_acc;

    logic                    div_start, div_busy, div_done, div_neg;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic signed [INVERSE_BITS-1:0] div_quo;

    act_mac #(
        .AW    (AW),
        .BW    (BW),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    act_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .OUT_W (INVERSE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_neg   (div_neg),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- operand helpers ----------------
    logic [7:0]              pair;
    logic [3:0]              rc_idx;
    logic [1:0]              ci;
    logic signed [COORD_BITS:0] dsub;
    logic signed [ADJ_W-1:0] adj_sel;
    logic [ADJ_W-1:0]        adj_mag;
    logic [DET_W-1:0]        det_mag;
    logic [C-1:0]            ts_mag;
    logic                    fwd_last, rev_last;

    assign pair    = act_pkg::adj_pair(r_k, r_p[0]);
    assign rc_idx  = ({2'b00, r_row} * 4'd3) + {2'b00, r_term};
    assign ci      = (r_row == 2'd3) ? 2'd3 : r_term;
    // reverse: coordinate minus offset, one bit wider
    assign dsub    = (COORD_BITS+1)'(r_in[ci]) - (COORD_BITS+1)'(r_off[ci]);
    assign adj_sel = (r_k == 4'd9) ? '0 : r_adj[r_k];
    assign adj_mag = adj_sel[ADJ_W-1] ? ADJ_W'(-adj_sel) : ADJ_W'(adj_sel);
    assign det_mag = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign ts_mag  = r_ts[C-1] ? C'(-r_ts) : C'(r_ts);
    assign fwd_last = (r_row == 2'd3) ? (r_term == 2'd1) : (r_term == 2'd3);
    assign rev_last = (r_row == 2'd3) ? (r_term == 2'd0) : (r_term == 2'd2);

    // round half up, drop fraction, saturate to the coordinate range
    logic signed [ACC_W-1:0]      rnd_sum;
    logic signed [RND_W-1:0]      rnd_q;
    logic                         rnd_fit;
    logic signed [COORD_BITS-1:0] rnd_val;

    assign rnd_sum = mac_acc + (ACC_W'(1) << (FB - 1));
    assign rnd_q   = rnd_sum[ACC_W-1:FB];
    assign rnd_fit = (&rnd_q[RND_W-1:COORD_BITS-1]) | ~(|rnd_q[RND_W-1:COORD_BITS-1]);
    assign rnd_val = rnd_fit ? rnd_q[COORD_BITS-1:0] : (rnd_q[RND_W-1] ? C_MIN : C_MAX);

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= act_pkg::S_IDLE;
            r_k      <= '0;
            r_p      <= '0;
            r_row    <= '0;
            r_term   <= '0;
            r_stale  <= 1'b1;
            r_inv_ok <= 1'b0;
            r_notinv <= 1'b0;
            r_sat    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_p      <= n_p;
            r_row    <= n_row;
            r_term   <= n_term;
            r_stale  <= n_stale;
            r_inv_ok <= n_inv_ok;
            r_notinv <= n_notinv;
            r_sat    <= n_sat;
            r_ov     <= n_ov;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_p       = r_p;
        n_row     = r_row;
        n_term    = r_term;
        n_stale   = r_stale;
        n_inv_ok  = r_inv_ok;
        n_notinv  = r_notinv;
        n_sat     = r_sat;
        mac_req   = '0;
        mac_a     = '0;
        mac_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;
        in_load   = 1'b0;
        adj_we    = 1'b0;
        det_we    = 1'b0;
        inv_we    = 1'b0;
        res_we    = 1'b0;
        out_load  = 1'b0;

        unique case (r_state)
            act_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    in_load  = 1'b1;
                    n_row    = '0;
                    n_term   = '0;
                    n_sat    = 1'b0;
                    n_notinv = 1'b0;
                    n_state  = act_pkg::S_START;
                end
            end
            act_pkg::S_START: begin
                if (r_cmd == act_pkg::CMD_FWD) begin
                    n_state = act_pkg::S_TERM;
                end else if (r_stale) begin
                    n_k     = '0;
                    n_p     = '0;
                    n_state = act_pkg::S_ADJ;
                end else if (!r_inv_ok) begin
                    n_notinv = 1'b1;
                    n_state  = act_pkg::S_PUSH;
                end else begin
                    n_state = act_pkg::S_TERM;
                end
            end
            // adjugate entry: a*b - c*d
            act_pkg::S_ADJ: begin
                mac_a = AW'(coef[pair[7:4]]);
                mac_b = BW'(coef[pair[3:0]]);
                if (!mac_busy) begin
                    mac_req.start = 1'b1;
                    mac_req.clr   = (r_p == 2'd0);
                    mac_req.sub   = (r_p == 2'd1);
                    if (r_p == 2'd1) begin
                        n_p     = '0;
                        n_state = act_pkg::S_ADJ_WAIT;
                    end else begin
                        n_p = r_p + 2'd1;
                    end
                end
            end
            act_pkg::S_ADJ_WAIT: begin
                if (!mac_busy) begin
                    adj_we = 1'b1;
                    if (r_k == 4'd8) begin
                        n_k     = '0;
                        n_state = act_pkg::S_DET;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = act_pkg::S_ADJ;
                    end
                end
            end
            // determinant along the first row against the first adjugate column
            act_pkg::S_DET: begin
                mac_a = AW'(coef[{2'b00, r_p}]);
                mac_b = BW'(r_adj[{2'b00, r_p} * 4'd3]);
                if (!mac_busy) begin
                    mac_req.start = 1'b1;
                    mac_req.clr   = (r_p == 2'd0);
                    if (r_p == 2'd2) begin
                        n_p     = '0;
                        n_state = act_pkg::S_DET_WAIT;
                    end else begin
                        n_p = r_p + 2'd1;
                    end
                end
            end
            act_pkg::S_DET_WAIT: begin
                if (!mac_busy) begin
                    det_we  = 1'b1;
                    n_state = act_pkg::S_CHECK;
                end
            end
            act_pkg::S_CHECK: begin
                n_inv_ok = (r_det != '0) && (r_ts != '0);
                n_k      = '0;
                if ((r_det != '0) && (r_ts != '0)) begin
                    n_state = act_pkg::S_DIV;
                end else begin
                    n_stale = 1'b0;
                    n_state = act_pkg::S_START;
                end
            end
            act_pkg::S_DIV: begin
                div_start = 1'b1;
                if (r_k == 4'd9) begin
                    div_num = NUM_W'(1) << (2 * FB);
                    div_den = DEN_W'(ts_mag);
                    div_neg = r_ts[C-1];
                end else begin
                    div_num = {adj_mag[2*C-1:0], {(2*FB){1'b0}}};
                    div_den = det_mag[DEN_W-1:0];
                    div_neg = adj_sel[ADJ_W-1] ^ r_det[DET_W-1];
                end
                n_state = act_pkg::S_DIV_WAIT;
            end
            act_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    inv_we = 1'b1;
                    if (r_k == 4'd9) begin
                        n_stale = 1'b0;
                        n_state = act_pkg::S_START;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = act_pkg::S_DIV;
                    end
                end
            end
            act_pkg::S_TERM: begin
                if (r_cmd == act_pkg::CMD_FWD) begin
                    if (r_term == 2'd0) begin
                        mac_a = ONE_A;
                        mac_b = BW'(r_off[r_row]);
                    end else if (r_row == 2'd3) begin
                        mac_a = AW'(r_ts);
                        mac_b = BW'(r_in[3]);
                    end else begin
                        mac_a = AW'(coef[rc_idx - 4'd1]);
                        mac_b = BW'(r_in[r_term - 2'd1]);
                    end
                end else begin
                    mac_a = (r_row == 2'd3) ? AW'(r_inv[9]) : AW'(r_inv[rc_idx]);
                    mac_b = BW'(dsub);
                end
                if (!mac_busy) begin
                    mac_req.start = 1'b1;
                    mac_req.clr   = (r_term == 2'd0);
                    if ((r_cmd == act_pkg::CMD_FWD) ? fwd_last : rev_last) begin
                        n_state = act_pkg::S_ROW_WAIT;
                    end else begin
                        n_term = r_term + 2'd1;
                    end
                end
            end
            act_pkg::S_ROW_WAIT: begin
                if (!mac_busy) begin
                    res_we = 1'b1;
                    n_sat  = r_sat | ~rnd_fit;
                    n_term = '0;
                    if (r_row == 2'd3) begin
                        n_state = act_pkg::S_PUSH;
                    end else begin
                        n_row   = r_row + 2'd1;
                        n_state = act_pkg::S_TERM;
                    end
                end
            end
            act_pkg::S_PUSH: begin
                if (!r_ov || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = act_pkg::S_IDLE;
                end
            end
            default: n_state = act_pkg::S_IDLE;
        endcase

        if (cfg_wr) begin
            n_stale = 1'b1;
        end
    end

    // result register: valid holds until taken
    assign n_ov = out_load | (r_ov & ~o_rsp.ready);

    // ---------------- datapath storage ----------------
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_cmd   <= i_req.command;
            r_in[0] <= i_req.x_in;
            r_in[1] <= i_req.y_in;
            r_in[2] <= i_req.z_in;
            r_in[3] <= i_req.t_in;
        end
        if (adj_we) begin
            r_adj[r_k] <= mac_acc[ADJ_W-1:0];
        end
        if (det_we) begin
            r_det <= mac_acc[DET_W-1:0];
        end
        if (inv_we) begin
            r_inv[r_k] <= div_quo;
        end
        if (res_we) begin
            r_res[r_row] <= rnd_val;
        end
        if (out_load) begin
            if (r_notinv) begin
                r_ox[0] <= '0;
                r_ox[1] <= '0;
                r_ox[2] <= '0;
                r_ox[3] <= '0;
                r_ostat <= act_pkg::STAT_NOT_INV;
            end else begin
                r_ox[0] <= r_res[0];
                r_ox[1] <= r_res[1];
                r_ox[2] <= r_res[2];
                r_ox[3] <= r_res[3];
                r_ostat <= r_sat ? act_pkg::STAT_SAT : act_pkg::STAT_OK;
            end
        end
    end

    assign i_req.ready  = (r_state == act_pkg::S_IDLE);
    assign o_rsp.valid  = r_ov;
    assign o_rsp.x_out  = r_ox[0];
    assign o_rsp.y_out  = r_ox[1];
    assign o_rsp.z_out  = r_ox[2];
    assign o_rsp.t_out  = r_ox[3];
    assign o_rsp.status = r_ostat;

    // ---------------- assertions ----------------
    `ACT_ASSERT_NOW(a_mac_free, mac_req.start, !mac_busy, "mac started while busy")
    `ACT_ASSERT_NOW(a_div_ok, div_start, r_inv_ok && !div_busy, "divide without invertible matrix")
    `ACT_ASSERT_NOW(a_notinv_zero, o_rsp.valid && (o_rsp.status == act_pkg::STAT_NOT_INV), (o_rsp.x_out == '0) && (o_rsp.t_out == '0), "non-invertible result not zero")
    `ACT_ASSERT_NEXT(a_accept_busy, i_req.valid && i_req.ready, r_state != act_pkg::S_IDLE, "request accepted but sequencer idle")

endmodule

`default_nettype wire

// ===== design/act_mac.sv =====
// Shared digit-serial multiply-accumulate unit.
`default_nettype none

module act_mac #(
    parameter int AW    = act_pkg::INVERSE_BITS_DEF,
    parameter int BW    = act_pkg::COORD_BITS_DEF + 1,
    parameter int ACC_W = act_pkg::INVERSE_BITS_DEF + act_pkg::COORD_BITS_DEF + 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  act_pkg::t_mac_req       i_req,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic                    o_busy,
    output logic signed [ACC_W-1:0] o_acc
);
    localparam int DG   = act_pkg::MUL_DIG;
    localparam int NCH  = (BW + DG - 1) / DG;
    localparam int SH_W = NCH * DG + 1;
    localparam int CK_W = $clog2(NCH) + 1;
    localparam int P_W  = AW + DG + 1;

    logic                    r_run, r_pv, r_sub, r_psub;
    logic signed [AW-1:0]    r_a;
    logic signed [SH_W-1:0]  r_b;
    logic [CK_W-1:0]         r_ck, r_pk;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic                    last;
    logic signed [DG:0]      digit;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] addend;

    // low digits are unsigned, the top digit carries the sign
    assign last   = (r_ck == CK_W'(NCH - 1));
    assign digit  = last ? r_b[DG:0] : {1'b0, r_b[DG-1:0]};
    assign prod   = r_a * digit;
    assign addend = ACC_W'(r_prod) <<< (r_pk * DG);
    assign o_busy = r_run | r_pv;
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pv  <= 1'b0;
            r_ck  <= '0;
        end else begin
            r_pv <= r_run;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_ck  <= '0;
            end else if (r_run) begin
                r_ck <= r_ck + CK_W'(1);
                if (last) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= SH_W'(i_b);
            r_sub <= i_req.sub;
        end else if (r_run) begin
            r_b <= r_b >>> DG;
        end
        if (r_run) begin
            r_prod <= prod;
            r_pk   <= r_ck;
            r_psub <= r_sub;
        end
        if (i_req.start && i_req.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_psub ? r_acc - addend : r_acc + addend;
        end
    end

endmodule

`default_nettype wire

// ===== design/act_div.sv =====
// Bit-serial restoring divider with round-half-away and clamping.
`default_nettype none

module act_div #(
    parameter int NUM_W = 2 * act_pkg::COEF_BITS_DEF + 2 * act_pkg::FRAC_BITS,
    parameter int DEN_W = 3 * act_pkg::COEF_BITS_DEF,
    parameter int OUT_W = act_pkg::INVERSE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic                    i_neg,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int LW    = (NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W;
    localparam logic [LW-1:0] LIM_POS = {{(LW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic [LW-1:0] LIM_NEG = LIM_POS + LW'(1);

    logic               r_run, r_fin, r_done, r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem, r_den;
    logic [NUM_W-1:0]   r_num;     // dividend shifts out, quotient shifts in
    logic signed [OUT_W-1:0] r_quo;

    logic [DEN_W:0]     rem2, rdiff;
    logic               ge, rnd;
    logic [LW-1:0]      q1, lim, qs;

    assign rem2  = {r_rem, r_num[NUM_W-1]};
    assign ge    = rem2 >= {1'b0, r_den};
    assign rdiff = rem2 - {1'b0, r_den};
    assign rnd   = {1'b0, r_rem, 1'b0} >= {2'b00, r_den};
    assign q1    = LW'(r_num) + LW'(rnd);
    assign lim   = r_neg ? LIM_NEG : LIM_POS;
    assign qs    = (q1 > lim) ? lim : q1;

    assign o_busy = r_run | r_fin;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_run) begin
            r_rem <= ge ? rdiff[DEN_W-1:0] : rem2[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], ge};
        end
        if (r_fin) begin
            r_quo <= r_neg ? -$signed(qs[OUT_W-1:0]) : $signed(qs[OUT_W-1:0]);
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the affine coordinate transform core.
`timescale 1ns / 1ps

module testbench;

    localparam int CB = act_pkg::COORD_BITS_DEF;
    localparam int KB = act_pkg::COEF_BITS_DEF;
    localparam int AB = act_pkg::ADDR_W;
    localparam int DB = act_pkg::DATA_W;
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [KB-1:0] KMAX = {1'b0, {(KB-1){1'b1}}};
    localparam logic signed [KB-1:0] KMIN = {1'b1, {(KB-1){1'b0}}};
    localparam logic signed [KB-1:0] KONE = 20'sd65536;

    typedef struct {
        logic signed [CB-1:0] x, y, z, t;
        logic [1:0]           status;
    } t_point;

    // Predicts every result from the register set in force when a request is accepted.
    class coord_scoreboard;
        logic [3*KB-1:0]      rows[3];
        logic signed [CB-1:0] offs[4];   // x, y, z, t
        logic signed [KB-1:0] tscale;
        logic signed [63:0]   inv_m[9];
        logic signed [63:0]   inv_ts;
        bit                   stale;
        bit                   invertible;
        t_point               pending[$];
        int                   errors;

        function new();
            for (int r = 0; r < 3; r++) rows[r] = (3*KB)'(KONE) << (r * KB);
            for (int i = 0; i < 4; i++) offs[i] = '0;
            tscale     = KONE;
            stale      = 1;
            invertible = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                act_pkg::REG_ROW0:   rows[0] = v[3*KB-1:0];
                act_pkg::REG_ROW1:   rows[1] = v[3*KB-1:0];
                act_pkg::REG_ROW2:   rows[2] = v[3*KB-1:0];
                act_pkg::REG_XOFF:   offs[0] = v[CB-1:0];
                act_pkg::REG_YOFF:   offs[1] = v[CB-1:0];
                act_pkg::REG_ZOFF:   offs[2] = v[CB-1:0];
                act_pkg::REG_TOFF:   offs[3] = v[CB-1:0];
                act_pkg::REG_TSCALE: tscale  = v[KB-1:0];
                default: ;
            endcase
            stale = 1;
        endfunction

        function logic signed [KB-1:0] coef(int r, int j);
            return rows[r][j*KB +: KB];
        endfunction

        // Round half up at bit 16, then clamp to the coordinate range.
        function logic signed [CB-1:0] round_sat(logic signed [127:0] acc, inout bit sat);
            logic signed [127:0] v;
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            v  = (acc + (128'sd1 <<< 15)) >>> 16;
            hi = CMAX;
            lo = CMIN;
            if (v > hi) begin
                sat = 1;
                return CMAX;
            end
            if (v < lo) begin
                sat = 1;
                return CMIN;
            end
            return v[CB-1:0];
        endfunction

        // num * 2^32 / den, nearest with ties away from zero, clamped to 32 bits.
        function logic signed [63:0] recip_entry(logic signed [127:0] num,
                                                 logic signed [127:0] den);
            bit            neg;
            logic [127:0]  mn, md, q, rem, lim;
            neg = (num < 0) != (den < 0);
            mn  = (num < 0) ? -num : num;
            md  = (den < 0) ? -den : den;
            q   = (mn << 32) / md;
            rem = (mn << 32) % md;
            if (rem >= md - rem) q++;
            lim = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
            if (q > lim) q = lim;
            return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        endfunction

        function void refresh_inverse();
            logic signed [127:0] m[9], adj[9], det, ts;
            for (int k = 0; k < 9; k++) m[k] = coef(k / 3, k % 3);
            adj[0] = m[4] * m[8] - m[5] * m[7];
            adj[3] = m[5] * m[6] - m[3] * m[8];
            adj[6] = m[3] * m[7] - m[4] * m[6];
            adj[1] = m[2] * m[7] - m[1] * m[8];
            adj[4] = m[0] * m[8] - m[2] * m[6];
            adj[7] = m[1] * m[6] - m[0] * m[7];
            adj[2] = m[1] * m[5] - m[2] * m[4];
            adj[5] = m[2] * m[3] - m[0] * m[5];
            adj[8] = m[0] * m[4] - m[1] * m[3];
            det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
            ts  = tscale;
            invertible = (det != 0) && (ts != 0);
            if (invertible) begin
                for (int k = 0; k < 9; k++) inv_m[k] = recip_entry(adj[k], det);
                inv_ts = recip_entry(128'sd1, ts);
            end
            stale = 0;
        endfunction

        function void note_request(logic cmd, logic signed [CB-1:0] x, y, z, t);
            t_point              e;
            logic signed [127:0] in[4], d[4], acc, tmp;
            bit                  sat;
            sat   = 0;
            in[0] = x; in[1] = y; in[2] = z; in[3] = t;
            if (cmd == act_pkg::CMD_FWD) begin
                for (int r = 0; r < 3; r++) begin
                    acc = offs[r];
                    acc = acc <<< 16;
                    for (int j = 0; j < 3; j++) begin
                        tmp = coef(r, j);
                        acc += tmp * in[j];
                    end
                    d[r] = round_sat(acc, sat);
                end
                acc = offs[3];
                acc = acc <<< 16;
                tmp = tscale;
                acc += tmp * in[3];
                d[3] = round_sat(acc, sat);
            end else begin
                if (stale) refresh_inverse();
                if (!invertible) begin
                    e.x = '0; e.y = '0; e.z = '0; e.t = '0;
                    e.status = act_pkg::STAT_NOT_INV;
                    pending.push_back(e);
                    return;
                end
                for (int j = 0; j < 4; j++) begin
                    tmp  = offs[j];
                    in[j] = in[j] - tmp;
                end
                for (int r = 0; r < 3; r++) begin
                    acc = 0;
                    for (int j = 0; j < 3; j++) begin
                        tmp = inv_m[r*3 + j];
                        acc += tmp * in[j];
                    end
                    d[r] = round_sat(acc, sat);
                end
                tmp  = inv_ts;
                d[3] = round_sat(tmp * in[3], sat);
            end
            e.x = d[0][CB-1:0]; e.y = d[1][CB-1:0];
            e.z = d[2][CB-1:0]; e.t = d[3][CB-1:0];
            e.status = sat ? act_pkg::STAT_SAT : act_pkg::STAT_OK;
            pending.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_point got);
            t_point e;
            if (pending.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) report($sformatf("x_out %h, want %h", got.x, e.x));
            if (got.y !== e.y) report($sformatf("y_out %h, want %h", got.y, e.y));
            if (got.z !== e.z) report($sformatf("z_out %h, want %h", got.z, e.z));
            if (got.t !== e.t) report($sformatf("t_out %h, want %h", got.t, e.t));
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [AB-1:0]     paddr;
    logic [DB-1:0]     pwdata;
    logic [DB-1:0]     prdata;
    logic              pready;
    bit                tx_calm;   // sender never idles
    bit                rx_calm;   // receiver never stalls

    act_req_if rq ();
    act_rsp_if rs ();

    coord_scoreboard sb = new();

    affine_coordinate_transform_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rq),
        .o_rsp   (rs),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs.
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stall before each result, none while rx_calm.
    initial begin
        int n;
        rs.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = rx_calm ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                rs.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rs.ready <= 1'b1;
            @(posedge i_clk);
            while (!rs.valid) @(posedge i_clk);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_point got;
        if (i_rst_n && rs.valid && rs.ready) begin
            got.x = rs.x_out; got.y = rs.y_out; got.z = rs.z_out; got.t = rs.t_out;
            got.status = rs.status;
            sb.check_result(got);
        end
    end

    // Register write: setup phase, then access phase until pready.
    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AB'(idx) << 3;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One request; valid stays up across back-to-back requests.
    task automatic send_request(logic cmd, logic signed [CB-1:0] x, y, z, t);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            rq.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rq.valid   <= 1'b1;
        rq.command <= cmd;
        rq.x_in    <= x;
        rq.y_in    <= y;
        rq.z_in    <= z;
        rq.t_in    <= t;
        @(posedge i_clk);
        while (!rq.ready) @(posedge i_clk);
        sb.note_request(cmd, x, y, z, t);
    endtask

    task automatic drain();
        rq.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            3: return CB'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return CB'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic signed [KB-1:0] pick_coef();
        case ($urandom_range(0, 7)) inside
            0: return KMAX;
            1: return KMIN;
            2: return '0;
            3, 4: return KB'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return KB'($urandom);
        endcase
    endfunction

    task automatic load_all(logic signed [KB-1:0] c[9], logic signed [CB-1:0] o[4],
                            logic signed [KB-1:0] ts);
        write_reg(act_pkg::REG_ROW0, 64'({c[2], c[1], c[0]}));
        write_reg(act_pkg::REG_ROW1, 64'({c[5], c[4], c[3]}));
        write_reg(act_pkg::REG_ROW2, 64'({c[8], c[7], c[6]}));
        write_reg(act_pkg::REG_XOFF, 64'(o[0]));
        write_reg(act_pkg::REG_YOFF, 64'(o[1]));
        write_reg(act_pkg::REG_ZOFF, 64'(o[2]));
        write_reg(act_pkg::REG_TOFF, 64'(o[3]));
        write_reg(act_pkg::REG_TSCALE, 64'(ts));
    endtask

    task automatic random_requests(int n);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        repeat (n)
            send_request(1'($urandom), pick_coord(), pick_coord(), pick_coord(),
                         pick_coord());
        drain();
    endtask

    initial begin
        logic signed [KB-1:0] c[9];
        logic signed [CB-1:0] o[4];
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        rq.valid   <= 1'b0;
        rq.command <= act_pkg::CMD_FWD;
        rq.x_in    <= '0;
        rq.y_in    <= '0;
        rq.z_in    <= '0;
        rq.t_in    <= '0;
        tx_calm    = 1;
        rx_calm    = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset identity: extremes both ways, first reverse builds the inverse.
        send_request(act_pkg::CMD_REV, CMAX, CMIN, '0, 48'sd1);
        send_request(act_pkg::CMD_FWD, CMAX, CMIN, '0, -48'sd1);
        send_request(act_pkg::CMD_FWD, CMIN, CMAX, CMAX, CMIN);
        send_request(act_pkg::CMD_REV, CMIN, CMAX, CMAX, CMIN);
        send_request(act_pkg::CMD_FWD, 48'sd1, -48'sd1, 48'sd65536, 48'sd32768);
        drain();

        // Scale of 8 on the diagonal: forward saturates at the coordinate limits.
        for (int k = 0; k < 9; k++) c[k] = (k % 4 == 0) ? KMAX : '0;
        o[0] = CMAX; o[1] = CMIN; o[2] = '0; o[3] = CMAX;
        load_all(c, o, KMIN);
        send_request(act_pkg::CMD_FWD, CMAX, CMIN, 48'sd1, CMIN);
        send_request(act_pkg::CMD_FWD, CMIN, CMAX, CMAX, CMAX);
        send_request(act_pkg::CMD_REV, CMIN, CMAX, CMIN, CMIN);
        send_request(act_pkg::CMD_REV, CMAX, CMIN, '0, '0);
        drain();

        // All rows equal: singular, reverse reports not invertible.
        for (int k = 0; k < 9; k++) c[k] = KMAX;
        o[0] = '0; o[1] = '0; o[2] = '0; o[3] = '0;
        load_all(c, o, KONE);
        send_request(act_pkg::CMD_REV, 48'sd5, 48'sd6, 48'sd7, 48'sd8);
        send_request(act_pkg::CMD_FWD, CMAX, CMAX, CMAX, CMAX);
        drain();

        // Zero time scale with a regular matrix: also not invertible.
        for (int k = 0; k < 9; k++) c[k] = (k % 4 == 0) ? KONE : '0;
        load_all(c, o, '0);
        send_request(act_pkg::CMD_REV, 48'sd100, -48'sd100, 48'sd3, 48'sd4);
        send_request(act_pkg::CMD_FWD, 48'sd100, -48'sd100, 48'sd3, 48'sd4);
        drain();

        // Smallest nonzero diagonal and scale: inverse entries clamp.
        for (int k = 0; k < 9; k++) c[k] = (k % 4 == 0) ? 20'sd1 : '0;
        c[1] = -20'sd1;
        load_all(c, o, -20'sd1);
        send_request(act_pkg::CMD_REV, 48'sd1, -48'sd1, 48'sd65536, -48'sd65536);
        send_request(act_pkg::CMD_REV, CMAX, CMIN, 48'sd2, 48'sd3);
        send_request(act_pkg::CMD_FWD, CMAX, CMIN, 48'sd2, 48'sd3);
        drain();

        // Most negative diagonal and scale, offsets at the extremes.
        for (int k = 0; k < 9; k++) c[k] = (k % 4 == 0) ? KMIN : '0;
        o[0] = CMIN; o[1] = CMAX; o[2] = CMIN; o[3] = CMIN;
        load_all(c, o, KMIN);
        random_requests(40);

        // Random register sets; the inverse is rebuilt after every set.
        repeat (9) begin
            for (int k = 0; k < 9; k++) c[k] = pick_coef();
            if ($urandom_range(0, 1)) begin
                for (int k = 0; k < 9; k++)
                    if (k % 4 != 0 && $urandom_range(0, 2) != 0) c[k] = '0;
            end
            for (int i = 0; i < 4; i++) o[i] = pick_coord();
            load_all(c, o, pick_coef());
            random_requests(155);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/act_pkg.sv
design/act_if.sv
design/act_mac.sv
design/act_div.sv
design/affine_coordinate_transform_core.sv
tb/sv/testbench.sv
